>>> rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

  localparam int KEY_W = 16;
  localparam int DATA_W = 31;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_LOAD
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic load;
  } lkvc_cmd_t;

endpackage

>>> rtl/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lkvc_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lkvc_ctrl.sv
// Request sequencer and output valid tracking for the LRU key-value cache.
`timescale 1ns / 1ps
module lkvc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lkvc_pkg::lkvc_cmd_t cmd
);

  lkvc_pkg::ctl_state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      lkvc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = lkvc_pkg::ST_LOOKUP;
        end
      end
      lkvc_pkg::ST_LOOKUP: begin
        state_next = lkvc_pkg::ST_LOAD;
      end
      lkvc_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = lkvc_pkg::ST_IDLE;
        end
      end
      default: state_next = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.load    = 1'b0;
    unique case (state)
      lkvc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      lkvc_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      lkvc_pkg::ST_LOAD: begin
        cmd.load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lkvc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("result register loaded without raising valid");

  a_lookup_once: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |=> !cmd.lookup && !in_ready)
    else $error("lookup repeated or input taken before result load");

endmodule

>>> rtl/lkvc_dpath.sv
// Cell row, recency ranks, data RAM and result register of the LRU key-value cache.
`timescale 1ns / 1ps
module lkvc_dpath #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lkvc_pkg::lkvc_cmd_t           cmd,
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                          opcode,
  input  logic [lkvc_pkg::KEY_W-1:0]    key,
  input  logic [lkvc_pkg::DATA_W-1:0]   value,
  output logic                          hit,
  output logic [lkvc_pkg::DATA_W-1:0]   read_value,
  output logic                          evicted
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

  logic [lkvc_pkg::CAP_W-1:0]  capacity;
  logic                        op_q;
  logic [lkvc_pkg::KEY_W-1:0]  key_q;
  logic [lkvc_pkg::DATA_W-1:0] value_q;

  logic [lkvc_pkg::KEY_W-1:0]  cell_key [ENTRIES];
  logic [RANK_W-1:0]           rank [ENTRIES];
  logic [RANK_W-1:0]           rank_next [ENTRIES];
  logic [ENTRIES-1:0]          valid;
  logic [CNT_W-1:0]            occ;

  logic [ENTRIES-1:0]          match;
  logic [IDX_W-1:0]            found_idx, free_idx, victim_idx, tgt_idx;
  logic [RANK_W-1:0]           promo_rank, last_rank;
  logic [CMP_W-1:0]            cap_ext, eff_cap;
  logic                        hit_c, full, do_update;

  logic                        hit_q, evict_q, rd_en_q;
  logic [IDX_W-1:0]            last_cell;
  logic [lkvc_pkg::DATA_W-1:0] ram_rdata;

  assign cap_ext   = CMP_W'(capacity);
  assign last_rank = RANK_W'(occ - CNT_W'(1));

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full = CMP_W'(occ) >= eff_cap;

  always_comb begin
    found_idx  = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid[i] && (cell_key[i] == key_q);
      if (match[i]) begin
        found_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
      if (valid[i] && (rank[i] == last_rank)) begin
        victim_idx = IDX_W'(i);
      end
    end
  end

  assign hit_c     = |match;
  assign do_update = hit_c || (op_q == lkvc_pkg::OP_PUT);

  always_comb begin
    if (hit_c) begin
      tgt_idx    = found_idx;
      promo_rank = rank[found_idx];
    end else if (full) begin
      tgt_idx    = victim_idx;
      promo_rank = rank[victim_idx];
    end else begin
      tgt_idx    = free_idx;
      promo_rank = RANK_W'(occ);
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_next[i] = rank[i];
      if (cmd.lookup && do_update) begin
        if (IDX_W'(i) == tgt_idx) begin
          rank_next[i] = '0;
        end else if (valid[i] && (rank[i] < promo_rank)) begin
          rank_next[i] = rank[i] + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= opcode;
      key_q   <= key;
      value_q <= value;
    end
    if (cmd.lookup) begin
      hit_q     <= hit_c;
      evict_q   <= !hit_c && (op_q == lkvc_pkg::OP_PUT) && full;
      rd_en_q   <= hit_c && (op_q == lkvc_pkg::OP_GET);
      last_cell <= tgt_idx;
      if (do_update && !hit_c) begin
        cell_key[tgt_idx] <= key_q;
      end
    end
    if (cmd.load) begin
      hit        <= hit_q;
      evicted    <= evict_q;
      read_value <= rd_en_q ? ram_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
      valid    <= '0;
      occ      <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
      valid    <= '0;
      occ      <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      rank <= rank_next;
      if (cmd.lookup && do_update) begin
        valid[tgt_idx] <= 1'b1;
        if (!hit_c && !full) begin
          occ <= occ + CNT_W'(1);
        end
      end
    end
  end

  lkvc_ram #(
    .WIDTH (lkvc_pkg::DATA_W),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk   (clk),
    .we    (cmd.lookup && (op_q == lkvc_pkg::OP_PUT)),
    .waddr (tgt_idx),
    .wdata (value_q),
    .re    (cmd.lookup),
    .raddr (found_idx),
    .rdata (ram_rdata)
  );

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(occ))
    else $error("occupied count out of step with valid cells");

  a_within_capacity: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(occ) <= eff_cap)
    else $error("store holds more entries than capacity allows");

  a_promoted_front: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup && do_update && !cfg_we |=> valid[last_cell] && (rank[last_cell] == '0))
    else $error("touched cell not made most recent");

endmodule

>>> rtl/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transaction:
//   opcode selects get or put, key is looked up, value is stored on put.
//   Output channel (out_valid/out_ready) returns one result per request:
//   hit, read_value (data on a get hit, else zero) and evicted.
//   cfg_we/cfg_wdata write the capacity register; a write empties the store.
// Sequence:
//   A request accepted on the input channel is compared against every cell
//   in the lookup state, which also updates the recency ranks on a hit or a
//   put and reads the data RAM; the load state loads the result register,
//   with the registered RAM read data, once the output register is free, and
//   out_valid is high after that load.
// Reset:
//   rst empties the store and sets capacity to 16.
// Back-pressure:
//   A finished result waits in the output register; the next request is
//   accepted meanwhile and waits with its result until out_ready frees it.
`timescale 1ns / 1ps
module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [lkvc_pkg::KEY_W-1:0]    key,
  input  logic [lkvc_pkg::DATA_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [lkvc_pkg::DATA_W-1:0]   read_value,
  output logic                          evicted
);

  lkvc_pkg::lkvc_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkvc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .opcode     (opcode),
    .key        (key),
    .value      (value),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted)
  );

endmodule

>>> dv/tb_lru_key_value_cache_core.sv
// Testbench for the LRU key-value cache core with a self-checking recency predictor.
`timescale 1ns / 1ps
module tb_lru_key_value_cache_core;

  localparam int ENTRIES = 16;

  typedef struct packed {
    logic                        hit;
    logic [lkvc_pkg::DATA_W-1:0] read_value;
    logic                        evicted;
  } lookup_result_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [lkvc_pkg::CAP_W-1:0]  cfg_wdata;
  logic                        in_valid;
  logic                        in_ready;
  logic                        opcode;
  logic [lkvc_pkg::KEY_W-1:0]  key;
  logic [lkvc_pkg::DATA_W-1:0] value;
  logic                        out_valid;
  logic                        out_ready;
  logic                        hit;
  logic [lkvc_pkg::DATA_W-1:0] read_value;
  logic                        evicted;

  lru_key_value_cache_core #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .key       (key),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .read_value(read_value),
    .evicted   (evicted)
  );

  // Predicted cache contents
  logic [lkvc_pkg::KEY_W-1:0]  shadow_key   [ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] shadow_data  [ENTRIES];
  bit                          shadow_valid [ENTRIES];
  int unsigned                 shadow_rank  [ENTRIES];
  int unsigned                 shadow_count;
  logic [lkvc_pkg::CAP_W-1:0]  shadow_cap;

  lookup_result_t pending_results[$];
  logic [lkvc_pkg::KEY_W-1:0] key_pool[$];
  int  error_count;
  bit  quiet_mode;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void clear_shadow();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i]   = '0;
      shadow_data[i]  = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = 0;
    end
    shadow_count = 0;
  endfunction

  function automatic int unsigned usable_capacity();
    if (shadow_cap == 0) return 1;
    if (shadow_cap > ENTRIES) return ENTRIES;
    return shadow_cap;
  endfunction

  function automatic void make_most_recent(int c);
    int unsigned r;
    r = shadow_rank[c];
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_valid[i] && i != c && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[c] = 0;
  endfunction

  function automatic lookup_result_t predict_lookup(logic op,
                                                    logic [lkvc_pkg::KEY_W-1:0] k,
                                                    logic [lkvc_pkg::DATA_W-1:0] v);
    lookup_result_t res;
    int found;
    int slot;
    int unsigned worst;
    res = '0;
    found = -1;
    slot = -1;
    worst = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && shadow_valid[i] && shadow_key[i] == k) found = i;
    if (found >= 0) begin
      res.hit = 1'b1;
      if (op == lkvc_pkg::OP_GET) res.read_value = shadow_data[found];
      else shadow_data[found] = v;
      make_most_recent(found);
    end else if (op == lkvc_pkg::OP_PUT) begin
      if (shadow_count >= usable_capacity()) begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i] && (slot < 0 || shadow_rank[i] >= worst)) begin
            worst = shadow_rank[i];
            slot = i;
          end
        res.evicted = 1'b1;
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !shadow_valid[i]) slot = i;
        if (slot >= 0) begin
          shadow_valid[slot] = 1'b1;
          shadow_rank[slot]  = shadow_count;
          shadow_count++;
        end
      end
      if (slot >= 0) begin
        shadow_key[slot]  = k;
        shadow_data[slot] = v;
        make_most_recent(slot);
      end else begin
        res.evicted = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic report_error(string what, logic [lkvc_pkg::DATA_W-1:0] exp_v,
                              logic [lkvc_pkg::DATA_W-1:0] got_v);
    $display("ERROR %0t: %s expected 0x%0h got 0x%0h", $time, what, exp_v, got_v);
    error_count++;
  endtask

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_error("unexpected result, hit", 0, hit);
      end else begin
        exp_r = pending_results.pop_front();
        if (hit !== exp_r.hit) report_error("hit", exp_r.hit, hit);
        if (read_value !== exp_r.read_value)
          report_error("read_value", exp_r.read_value, read_value);
        if (evicted !== exp_r.evicted) report_error("evicted", exp_r.evicted, evicted);
      end
    end
  end

  // Output back-pressure in random bursts
  always @(posedge clk) begin
    if (quiet_mode) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(logic op, logic [lkvc_pkg::KEY_W-1:0] k,
                              logic [lkvc_pkg::DATA_W-1:0] v);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_lookup(op, k, v));
  endtask

  // Hold off the input until every predicted result has been returned
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cap = cap;
    clear_shadow();
  endtask

  function automatic logic [lkvc_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return lkvc_pkg::DATA_W'($urandom());
    endcase
  endfunction

  function automatic logic [lkvc_pkg::KEY_W-1:0] pick_key();
    if (key_pool.size() == 0 || $urandom_range(0, 9) < 2)
      return lkvc_pkg::KEY_W'($urandom());
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task automatic build_key_pool(int n);
    key_pool.delete();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       key_pool.push_back('0);
        1:       key_pool.push_back({lkvc_pkg::KEY_W{1'b1}});
        default: key_pool.push_back(lkvc_pkg::KEY_W'($urandom()));
      endcase
    end
  endtask

  task automatic test_get_put_basic();
    send_request(lkvc_pkg::OP_GET, 16'h0000, 31'h1234_5678);
    send_request(lkvc_pkg::OP_PUT, 16'h0000, 31'h0000_0000);
    send_request(lkvc_pkg::OP_PUT, 16'hFFFF, 31'h7FFF_FFFF);
    send_request(lkvc_pkg::OP_GET, 16'hFFFF, 31'h0000_0000);
    send_request(lkvc_pkg::OP_GET, 16'h0000, 31'h7FFF_FFFF);
    send_request(lkvc_pkg::OP_PUT, 16'h0000, 31'h5555_5555);
    send_request(lkvc_pkg::OP_GET, 16'h0000, 31'h0);
    send_request(lkvc_pkg::OP_GET, 16'h1234, 31'h0);
  endtask

  task automatic test_capacity_zero();
    write_capacity(5'd0);
    send_request(lkvc_pkg::OP_PUT, 16'h00A1, 31'h2AAA_AAAA);
    send_request(lkvc_pkg::OP_PUT, 16'h00B2, 31'h1111_1111);
    send_request(lkvc_pkg::OP_GET, 16'h00A1, 31'h0);
    send_request(lkvc_pkg::OP_GET, 16'h00B2, 31'h0);
  endtask

  task automatic test_lru_order();
    write_capacity(5'd3);
    send_request(lkvc_pkg::OP_PUT, 16'h0001, 31'd10);
    send_request(lkvc_pkg::OP_PUT, 16'h0002, 31'd20);
    send_request(lkvc_pkg::OP_PUT, 16'h0003, 31'd30);
    send_request(lkvc_pkg::OP_GET, 16'h0001, 31'd0);
    send_request(lkvc_pkg::OP_PUT, 16'h0004, 31'd40);
    send_request(lkvc_pkg::OP_GET, 16'h0002, 31'd0);
    send_request(lkvc_pkg::OP_PUT, 16'h0003, 31'd33);
    send_request(lkvc_pkg::OP_PUT, 16'h0005, 31'd50);
    send_request(lkvc_pkg::OP_GET, 16'h0001, 31'd0);
  endtask

  task automatic run_random_phase(logic [lkvc_pkg::CAP_W-1:0] cap, int n_items);
    int pool_n;
    write_capacity(cap);
    pool_n = $urandom_range(1, usable_capacity() + 8);
    build_key_pool(pool_n);
    for (int i = 0; i < n_items; i++) begin
      send_request(logic'($urandom_range(0, 1)), pick_key(), pick_value());
      if (i == n_items / 2 && $urandom_range(0, 1) == 0) wait_idle();
    end
  endtask

  task automatic test_random_capacities();
    logic [lkvc_pkg::CAP_W-1:0] caps[$];
    caps = '{5'd1, 5'd2, 5'd3, 5'd7, 5'd8, 5'd15, 5'd16, 5'd17, 5'd31, 5'd0};
    caps.push_back(lkvc_pkg::CAP_W'($urandom()));
    foreach (caps[i]) run_random_phase(caps[i], 110);
  endtask

  task automatic test_back_to_back();
    quiet_mode = 1'b1;
    run_random_phase(5'd16, 60);
    run_random_phase(5'd4, 60);
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    opcode      = lkvc_pkg::OP_GET;
    key         = '0;
    value       = '0;
    out_ready   = 1'b0;
    stall_left  = 0;
    quiet_mode  = 1'b0;
    error_count = 0;
    shadow_cap  = lkvc_pkg::CAP_RESET;
    clear_shadow();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_get_put_basic();
    test_capacity_zero();
    test_lru_order();
    test_random_capacities();
    test_back_to_back();

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lkvc_pkg.sv
rtl/lkvc_ram.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_dpath.sv
rtl/lru_key_value_cache_core.sv
dv/tb_lru_key_value_cache_core.sv
